FILE: rtl/scaf_pkg.sv
// Shared types, constants and the set-1 make-code table for the scancode FIFO.
package scaf_pkg;

    localparam int CHAR_W = 7;
    localparam int CODE_W = 8;
    localparam int MAKE_TABLE_SIZE = 58;
    localparam int BREAK_BIT = 7;

    // Request kinds carried on the action field.
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [CODE_W-1:0] code_t;

    // Decoded keyboard event: a character that is to be pushed.
    typedef struct packed {
        logic  push;
        char_t ch;
    } scaf_key_t;

    // Unshifted set-1 make codes; unused codes give zero.
    function automatic char_t make_map(input logic [5:0] idx);
        char_t c;
        c = '0;
        case (idx)
            6'd1:    c = 7'h1B;
            6'd2:    c = 7'h31;
            6'd3:    c = 7'h32;
            6'd4:    c = 7'h33;
            6'd5:    c = 7'h34;
            6'd6:    c = 7'h35;
            6'd7:    c = 7'h36;
            6'd8:    c = 7'h37;
            6'd9:    c = 7'h38;
            6'd10:   c = 7'h39;
            6'd11:   c = 7'h30;
            6'd12:   c = 7'h2D;
            6'd13:   c = 7'h3D;
            6'd14:   c = 7'h08;
            6'd15:   c = 7'h09;
            6'd16:   c = 7'h71;
            6'd17:   c = 7'h77;
            6'd18:   c = 7'h65;
            6'd19:   c = 7'h72;
            6'd20:   c = 7'h74;
            6'd21:   c = 7'h79;
            6'd22:   c = 7'h75;
            6'd23:   c = 7'h69;
            6'd24:   c = 7'h6F;
            6'd25:   c = 7'h70;
            6'd26:   c = 7'h5B;
            6'd27:   c = 7'h5D;
            6'd28:   c = 7'h0A;
            6'd30:   c = 7'h61;
            6'd31:   c = 7'h73;
            6'd32:   c = 7'h64;
            6'd33:   c = 7'h66;
            6'd34:   c = 7'h67;
            6'd35:   c = 7'h68;
            6'd36:   c = 7'h6A;
            6'd37:   c = 7'h6B;
            6'd38:   c = 7'h6C;
            6'd39:   c = 7'h3B;
            6'd40:   c = 7'h27;
            6'd41:   c = 7'h60;
            6'd43:   c = 7'h5C;
            6'd44:   c = 7'h7A;
            6'd45:   c = 7'h78;
            6'd46:   c = 7'h63;
            6'd47:   c = 7'h76;
            6'd48:   c = 7'h62;
            6'd49:   c = 7'h6E;
            6'd50:   c = 7'h6D;
            6'd51:   c = 7'h2C;
            6'd52:   c = 7'h2E;
            6'd53:   c = 7'h2F;
            6'd55:   c = 7'h2A;
            6'd57:   c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/scaf_map.sv
// Scancode decoder: drops break codes and maps make codes to ASCII.
module scaf_map
    import scaf_pkg::*;
(
    input  code_t     scan_code,
    output scaf_key_t key
);

    // A break code or a code past the table yields no character.
    always_comb
    begin
        key.ch = '0;
        if (!scan_code[BREAK_BIT] && (scan_code < code_t'(MAKE_TABLE_SIZE)))
        begin
            key.ch = make_map(scan_code[5:0]);
        end
        key.push = (key.ch != '0);
    end

endmodule

FILE: rtl/scaf_store.sv
// Character storage: one write port and one registered read port.
module scaf_store
    import scaf_pkg::*;
#(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  char_t             wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output char_t             rd_data
);

    char_t mem [DEPTH];
    char_t rd_data_reg;

    // Synchronous write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read into the output register.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/scancode_ascii_fifo_core.sv
// Scancode to ASCII FIFO: the top level with pointers, handshake and result register.
// It takes one request per cycle while the result side does not stall.
// The memory read and the pending stage load at the accept edge, then the result register.
// Reset clears both pointers, the pending flag and out_valid; the character store is not cleared,
// since only written entries are ever read, so there is no clearing pass after reset.
module scancode_ascii_fifo_core
    import scaf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 128
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  action,
    input  code_t scan_code,
    output logic  out_valid,
    input  logic  out_stall,
    output char_t read_char,
    output logic  read_valid,
    output logic  not_empty,
    output logic  dropped_full
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    logic             pend_reg, pend_next;
    logic             pend_rvalid_reg, pend_ne_reg, pend_drop_reg;
    logic             out_valid_reg, out_valid_next;
    char_t            read_char_reg;
    logic             read_valid_reg, not_empty_reg, dropped_full_reg;
    logic             accept, out_free, buf_empty, buf_full;
    logic             do_push, do_pop, do_drop;
    scaf_key_t        key;
    char_t            rd_data;

    scaf_map u_map (
        .scan_code (scan_code),
        .key       (key)
    );

    scaf_store #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (do_push),
        .wr_addr (wr_ptr_reg),
        .wr_data (key.ch),
        .rd_en   (do_pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    // Handshake: a request waits only when a pending result cannot move on.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = pend_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // Ring pointer arithmetic with wrap at the buffer depth.
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign buf_empty  = (rd_ptr_reg == wr_ptr_reg);
    assign buf_full   = (wr_ptr_inc == rd_ptr_reg);

    // Decide what the accepted request does to the buffer.
    assign do_push = accept && (action == ACT_SCAN) && key.push && !buf_full;
    assign do_drop = accept && (action == ACT_SCAN) && key.push && buf_full;
    assign do_pop  = accept && (action == ACT_READ) && !buf_empty;

    assign wr_ptr_next = do_push ? wr_ptr_inc : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_inc : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Pending stage: holds the result flags while the memory read completes.
    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (out_free)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_rvalid_reg <= do_pop;
            pend_ne_reg     <= (rd_ptr_next != wr_ptr_next);
            pend_drop_reg   <= do_drop;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pend_reg && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && out_free)
        begin
            read_char_reg    <= pend_rvalid_reg ? rd_data : '0;
            read_valid_reg   <= pend_rvalid_reg;
            not_empty_reg    <= pend_ne_reg;
            dropped_full_reg <= pend_drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_char    = read_char_reg;
    assign read_valid   = read_valid_reg;
    assign not_empty    = not_empty_reg;
    assign dropped_full = dropped_full_reg;

    // A dropped character means the buffer was full, so it cannot be empty.
    a_drop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped_full |-> not_empty)
        else $error("dropped character reported with an empty buffer");

    // A request either reads or drops, never both.
    a_read_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(read_valid && dropped_full))
        else $error("read and drop flagged in the same result");

    // A failed read carries a zero character.
    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_char == '0)
        else $error("nonzero character without read_valid");

    // A push never fills the last free slot.
    a_push_keeps_gap: assert property (@(posedge clk) disable iff (!rst_n)
        do_push |=> wr_ptr_reg != rd_ptr_reg)
        else $error("write pointer caught up with read pointer");

endmodule

FILE: tb/sv/scancode_ascii_fifo_core_tb.sv
// Self-checking testbench for the scancode to ASCII character FIFO core.
module scancode_ascii_fifo_core_tb
    import scaf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = 128;
    localparam int HOLD_CYC  = 300;
    localparam int DRAIN_CYC = 20000;

    // One result of the block as the checker sees it.
    typedef struct packed {
        char_t ch;
        logic  valid;
        logic  not_empty;
        logic  dropped;
    } key_outcome_t;

    // Tracks the character buffer and checks results in request order.
    class keybuf_scoreboard;

        char_t        key_store [DEPTH];
        int           rd_idx;
        int           wr_idx;
        key_outcome_t key_outcomes [$];
        int           mismatches;

        function new();
            rd_idx     = 0;
            wr_idx     = 0;
            mismatches = 0;
        endfunction

        // Unshifted set-1 make codes; codes past the table give zero.
        static function char_t key_char(code_t code);
            char_t keymap [0:MAKE_TABLE_SIZE-1];
            keymap = '{
                7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
                7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
                7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
                7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
                7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
                7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20};
            if (code >= MAKE_TABLE_SIZE)
                return '0;
            return keymap[code];
        endfunction

        function int pending();
            return key_outcomes.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Updates the buffer for one accepted request and queues its result.
        function void note_request(logic act, code_t code);
            key_outcome_t o;
            char_t        c;
            int           nxt;
            o = '0;
            if (act == ACT_SCAN)
            begin
                if (!code[BREAK_BIT])
                begin
                    c = key_char(code);
                    if (c != '0)
                    begin
                        nxt = (wr_idx + 1) % DEPTH;
                        if (nxt != rd_idx)
                        begin
                            key_store[wr_idx] = c;
                            wr_idx = nxt;
                        end
                        else
                            o.dropped = 1'b1;
                    end
                end
            end
            else if (rd_idx != wr_idx)
            begin
                o.ch    = key_store[rd_idx];
                o.valid = 1'b1;
                rd_idx  = (rd_idx + 1) % DEPTH;
            end
            o.not_empty = (rd_idx != wr_idx);
            key_outcomes.push_back(o);
        endfunction

        // Compares one accepted result with the oldest queued one.
        task check_result(char_t ch, logic vld, logic ne, logic dr);
            key_outcome_t o;
            if (key_outcomes.size() == 0)
            begin
                report_mismatch("result arrived with no request waiting");
                return;
            end
            o = key_outcomes.pop_front();
            if (ch !== o.ch)
                report_mismatch($sformatf("read_char %h, expected %h", ch, o.ch));
            if (vld !== o.valid)
                report_mismatch($sformatf("read_valid %b, expected %b", vld, o.valid));
            if (ne !== o.not_empty)
                report_mismatch($sformatf("not_empty %b, expected %b", ne, o.not_empty));
            if (dr !== o.dropped)
                report_mismatch($sformatf("dropped_full %b, expected %b", dr, o.dropped));
        endtask

    endclass

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  in_valid   = 1'b0;
    logic  in_stall;
    logic  action     = ACT_SCAN;
    code_t scan_code  = '0;
    logic  out_valid;
    logic  out_stall  = 1'b0;
    char_t read_char;
    logic  read_valid;
    logic  not_empty;
    logic  dropped_full;

    bit quiet   = 1'b0;
    bit hold_go = 1'b0;
    bit hold_on = 1'b0;

    keybuf_scoreboard sb = new();

    scancode_ascii_fifo_core #(.BUFFER_DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .scan_code    (scan_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_char    (read_char),
        .read_valid   (read_valid),
        .not_empty    (not_empty),
        .dropped_full (dropped_full)
    );

    // Free-running 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Offers one request, with random idle cycles ahead of it, until it is taken.
    task automatic send_request(logic act, code_t code);
        while (!quiet && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        scan_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, code);
    endtask

    // Picks a scancode: mostly mapped make codes, then out-of-table codes, breaks and noise.
    function automatic code_t pick_code();
        int    r;
        code_t c;
        r = $urandom_range(99);
        if (r < 70)
        begin
            c = code_t'($urandom_range(MAKE_TABLE_SIZE - 1));
            while (keybuf_scoreboard::key_char(c) == '0)
                c = code_t'($urandom_range(MAKE_TABLE_SIZE - 1));
        end
        else if (r < 80)
            c = code_t'($urandom_range(127, MAKE_TABLE_SIZE));
        else if (r < 90)
            c = code_t'($urandom) | 8'h80;
        else
            c = code_t'($urandom);
        return c;
    endfunction

    // Runs a stretch of random requests with the given share of scancodes.
    task automatic run_phase(int count, int scan_pct);
        logic act;
        for (int i = 0; i < count; i++)
        begin
            act = ($urandom_range(99) < scan_pct) ? ACT_SCAN : ACT_READ;
            send_request(act, (act == ACT_SCAN) ? pick_code() : code_t'($urandom));
        end
    endtask

    // Result side: check accepted results and drive the stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(read_char, read_valid, not_empty, dropped_full);
        out_stall <= rst_n && (hold_on || (!quiet && $urandom_range(99) < 18));
    end

    // Long hold-off on the result side so the pipe backs up into the input.
    initial
    begin
        wait (hold_go);
        hold_on = 1'b1;
        repeat (HOLD_CYC) @(posedge clk);
        hold_on = 1'b0;
    end

    // Main sequence: reset, directed requests, random phases, drain.
    initial
    begin
        int guard;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Read from an empty buffer, then mapped, dead, out-of-table and break codes.
        send_request(ACT_READ, 8'hFF);
        send_request(ACT_SCAN, 8'h00);
        send_request(ACT_SCAN, 8'h01);
        send_request(ACT_SCAN, 8'h02);
        send_request(ACT_SCAN, 8'h39);
        send_request(ACT_SCAN, 8'h3A);
        send_request(ACT_SCAN, 8'h7F);
        send_request(ACT_SCAN, 8'h80);
        send_request(ACT_SCAN, 8'h81);
        send_request(ACT_SCAN, 8'hFF);
        send_request(ACT_SCAN, 8'h1D);
        send_request(ACT_SCAN, 8'h2A);
        send_request(ACT_SCAN, 8'h36);
        send_request(ACT_SCAN, 8'h38);
        send_request(ACT_SCAN, 8'h1C);
        send_request(ACT_SCAN, 8'h10);
        send_request(ACT_READ, 8'h00);
        send_request(ACT_READ, 8'h55);
        send_request(ACT_READ, 8'hAA);
        send_request(ACT_READ, 8'h0F);
        send_request(ACT_READ, 8'hF0);
        send_request(ACT_READ, 8'h01);

        // Fill past capacity so pushes get dropped.
        run_phase(220, 96);
        // Stretch with no idling on either side.
        quiet = 1'b1;
        run_phase(100, 50);
        quiet = 1'b0;
        // Drain while the result side holds off for a while.
        hold_go = 1'b1;
        run_phase(150, 10);
        run_phase(60, 50);
        in_valid <= 1'b0;

        guard = 0;
        while (sb.pending() > 0 && guard < DRAIN_CYC)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);

        if (sb.pending() > 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #3000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/scaf_pkg.sv
rtl/scaf_map.sv
rtl/scaf_store.sv
rtl/scancode_ascii_fifo_core.sv
tb/sv/scancode_ascii_fifo_core_tb.sv
